// File: rtl/bpfa_pkg.sv
package bpfa_pkg;

  // Default geometry of the free-page bitmap
  localparam int unsigned NUM_WORDS_DEF = 512;
  localparam int unsigned WORD_BITS_DEF = 64;

  // Fixed field widths
  localparam int PAGE_W = 15;
  localparam int STEP_W = 5;

  // Request codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FREE = 2'd1,
    ST_RANGE   = 2'd2,
    ST_DUP     = 2'd3
  } status_t;

  // Datapath actions, one per control word
  typedef enum logic [4:0] {
    ACT_NONE,
    ACT_CLEAR,
    ACT_ACCEPT,
    ACT_READ_HINT,
    ACT_CLEAR_HINT,
    ACT_READ_SCAN,
    ACT_SCAN_STEP,
    ACT_FIND_GROUP,
    ACT_SET_HINT,
    ACT_RES_EMPTY,
    ACT_DIV_EST,
    ACT_DIV_FIX,
    ACT_READ_PAGE,
    ACT_FREE_COMMIT,
    ACT_RES_RANGE,
    ACT_RES_DUP,
    ACT_EMIT
  } act_t;

  // Sequencing: advance, branch on flag, or wait on flag
  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_IF,
    JMP_HOLD
  } jmp_t;

  // Condition flags the sequencer can test
  typedef enum logic [3:0] {
    F_ALWAYS,
    F_CLR_MORE,
    F_IN_FIRE,
    F_IS_FREE,
    F_COUNT_ZERO,
    F_COUNT_ONE,
    F_SCAN_MORE,
    F_WORD_ZERO,
    F_OUT_RANGE,
    F_BIT_SET,
    F_OUT_FREE
  } flag_t;

  typedef logic [STEP_W-1:0] step_t;

  typedef struct packed {
    act_t  act;
    jmp_t  jmp;
    flag_t flag;
    step_t target;
  } uword_t;

  typedef struct packed {
    logic clr_more;
    logic in_fire;
    logic is_free;
    logic count_zero;
    logic count_one;
    logic scan_more;
    logic word_zero;
    logic out_range;
    logic bit_set;
    logic out_free;
  } flags_t;

  // Program step addresses
  localparam step_t S_CLR    = 5'd0;
  localparam step_t S_IDLE   = 5'd1;
  localparam step_t S_DISP   = 5'd2;
  localparam step_t S_A0     = 5'd3;
  localparam step_t S_A1     = 5'd4;
  localparam step_t S_A2     = 5'd5;
  localparam step_t S_S0     = 5'd6;
  localparam step_t S_S1     = 5'd7;
  localparam step_t S_S2     = 5'd8;
  localparam step_t S_S3     = 5'd9;
  localparam step_t S_AEMPTY = 5'd10;
  localparam step_t S_F0     = 5'd11;
  localparam step_t S_F1     = 5'd12;
  localparam step_t S_F2     = 5'd13;
  localparam step_t S_F3     = 5'd14;
  localparam step_t S_F4     = 5'd15;
  localparam step_t S_FRANGE = 5'd16;
  localparam step_t S_FDUP   = 5'd17;
  localparam step_t S_EMIT   = 5'd18;

  function automatic uword_t uw_make(act_t a, jmp_t j, flag_t f, step_t t);
    uword_t w;
    w.act    = a;
    w.jmp    = j;
    w.flag   = f;
    w.target = t;
    return w;
  endfunction

  // Control store
  function automatic uword_t ucode(step_t s);
    uword_t w;
    case (s)
      // clear the bitmap one word per step after reset
      S_CLR:    w = uw_make(ACT_CLEAR,       JMP_IF,   F_CLR_MORE,   S_CLR);
      S_IDLE:   w = uw_make(ACT_ACCEPT,      JMP_HOLD, F_IN_FIRE,    S_DISP);
      S_DISP:   w = uw_make(ACT_NONE,        JMP_IF,   F_IS_FREE,    S_F0);
      // allocate
      S_A0:     w = uw_make(ACT_NONE,        JMP_IF,   F_COUNT_ZERO, S_AEMPTY);
      S_A1:     w = uw_make(ACT_READ_HINT,   JMP_NEXT, F_ALWAYS,     S_CLR);
      S_A2:     w = uw_make(ACT_CLEAR_HINT,  JMP_IF,   F_COUNT_ONE,  S_EMIT);
      S_S0:     w = uw_make(ACT_READ_SCAN,   JMP_NEXT, F_ALWAYS,     S_CLR);
      S_S1:     w = uw_make(ACT_SCAN_STEP,   JMP_IF,   F_SCAN_MORE,  S_S0);
      S_S2:     w = uw_make(ACT_FIND_GROUP,  JMP_IF,   F_WORD_ZERO,  S_EMIT);
      S_S3:     w = uw_make(ACT_SET_HINT,    JMP_IF,   F_ALWAYS,     S_EMIT);
      S_AEMPTY: w = uw_make(ACT_RES_EMPTY,   JMP_IF,   F_ALWAYS,     S_EMIT);
      // free
      S_F0:     w = uw_make(ACT_DIV_EST,     JMP_IF,   F_OUT_RANGE,  S_FRANGE);
      S_F1:     w = uw_make(ACT_DIV_FIX,     JMP_NEXT, F_ALWAYS,     S_CLR);
      S_F2:     w = uw_make(ACT_READ_PAGE,   JMP_NEXT, F_ALWAYS,     S_CLR);
      S_F3:     w = uw_make(ACT_NONE,        JMP_IF,   F_BIT_SET,    S_FDUP);
      S_F4:     w = uw_make(ACT_FREE_COMMIT, JMP_IF,   F_ALWAYS,     S_EMIT);
      S_FRANGE: w = uw_make(ACT_RES_RANGE,   JMP_IF,   F_ALWAYS,     S_EMIT);
      S_FDUP:   w = uw_make(ACT_RES_DUP,     JMP_IF,   F_ALWAYS,     S_EMIT);
      // hand the result to the output register
      S_EMIT:   w = uw_make(ACT_EMIT,        JMP_HOLD, F_OUT_FREE,   S_IDLE);
      default:  w = uw_make(ACT_NONE,        JMP_IF,   F_ALWAYS,     S_IDLE);
    endcase
    return w;
  endfunction

endpackage

// File: rtl/bpfa_seq.sv
module bpfa_seq (
  input  logic              clk,
  input  logic              rst,
  input  bpfa_pkg::flags_t  flags,
  output bpfa_pkg::uword_t  uw
);

  bpfa_pkg::step_t step;
  bpfa_pkg::step_t step_next;
  logic            cond;

  // Fetch the control word of the current step
  assign uw = bpfa_pkg::ucode(step);

  // Select the tested flag
  always_comb begin
    case (uw.flag)
      bpfa_pkg::F_ALWAYS:     cond = 1'b1;
      bpfa_pkg::F_CLR_MORE:   cond = flags.clr_more;
      bpfa_pkg::F_IN_FIRE:    cond = flags.in_fire;
      bpfa_pkg::F_IS_FREE:    cond = flags.is_free;
      bpfa_pkg::F_COUNT_ZERO: cond = flags.count_zero;
      bpfa_pkg::F_COUNT_ONE:  cond = flags.count_one;
      bpfa_pkg::F_SCAN_MORE:  cond = flags.scan_more;
      bpfa_pkg::F_WORD_ZERO:  cond = flags.word_zero;
      bpfa_pkg::F_OUT_RANGE:  cond = flags.out_range;
      bpfa_pkg::F_BIT_SET:    cond = flags.bit_set;
      bpfa_pkg::F_OUT_FREE:   cond = flags.out_free;
      default:                cond = 1'b0;
    endcase
  end

  // Advance, branch or wait
  always_comb begin
    case (uw.jmp)
      bpfa_pkg::JMP_NEXT: step_next = step + bpfa_pkg::STEP_W'(1);
      bpfa_pkg::JMP_IF:   step_next = cond ? uw.target : step + bpfa_pkg::STEP_W'(1);
      bpfa_pkg::JMP_HOLD: step_next = cond ? uw.target : step;
      default:            step_next = bpfa_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= bpfa_pkg::S_CLR;
    end else begin
      step <= step_next;
    end
  end

endmodule

// File: rtl/bpfa_dp.sv
module bpfa_dp #(
  parameter int unsigned NUM_WORDS = bpfa_pkg::NUM_WORDS_DEF,
  parameter int unsigned WORD_BITS = bpfa_pkg::WORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bpfa_pkg::uword_t              uw,
  output bpfa_pkg::flags_t              flags,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          opcode,
  input  logic [bpfa_pkg::PAGE_W-1:0]   page_number,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bpfa_pkg::PAGE_W-1:0]   alloc_page,
  output logic [1:0]                    status
);

  localparam int          PW     = bpfa_pkg::PAGE_W;
  localparam int          WA_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int          HB_W   = $clog2(WORD_BITS);
  localparam int unsigned TOTAL  = NUM_WORDS * WORD_BITS;
  localparam int          CNT_W  = $clog2(TOTAL + 1);
  localparam int          RCP_SH = 20;
  localparam logic [17:0] RECIP  = 18'((2 ** RCP_SH) / WORD_BITS);
  localparam logic [WA_W-1:0] LAST_W = WA_W'(NUM_WORDS - 1);

  // Bitmap store, one bit per page, set means free
  logic [WORD_BITS-1:0] mem [NUM_WORDS];
  logic [WORD_BITS-1:0] rd_data;
  logic                 mem_we;
  logic                 mem_re;
  logic [WA_W-1:0]      mem_addr;
  logic [WORD_BITS-1:0] mem_wd;

  // Control state
  logic [WA_W-1:0]  scan_w;
  logic [WA_W-1:0]  hint_word;
  logic [HB_W-1:0]  hint_bit;
  logic [CNT_W-1:0] free_count;

  // Item payload and working registers
  logic                 op_reg;
  logic [PW-1:0]        pg;
  logic [PW-1:0]        q;
  logic [WA_W-1:0]      fw;
  logic [HB_W-1:0]      fb;
  logic [2:0]           grp;
  logic [7:0]           grp_byte;
  logic [PW-1:0]        res_page;
  bpfa_pkg::status_t    res_status;

  // Combinational helpers
  logic [CNT_W-1:0]     hint_page;
  logic                 pg_lt_hint;
  logic [32:0]          prod;
  logic [PW-1:0]        q_est;
  logic [15:0]          rem;
  logic [PW-1:0]        q_fix;
  logic [15:0]          rem_fix;
  logic [63:0]          word_pad;
  logic [2:0]           grp_c;
  logic [2:0]           bit_c;
  logic [HB_W-1:0]      new_hint_bit;
  logic [WORD_BITS-1:0] hint_mask;
  logic [WORD_BITS-1:0] page_mask;
  logic                 in_fire;
  logic                 out_free;
  logic                 word_zero;

  assign in_ready  = (uw.act == bpfa_pkg::ACT_ACCEPT);
  assign in_fire   = in_valid & in_ready;
  assign out_free  = !out_valid || out_ready;
  assign word_zero = (rd_data == '0);

  assign hint_page  = CNT_W'(hint_word) * CNT_W'(WORD_BITS) + CNT_W'(hint_bit);
  assign pg_lt_hint = 32'(pg) < 32'(hint_page);

  // Split the page number into word and bit: reciprocal estimate, then one correction
  assign prod    = 33'(pg) * 33'(RECIP);
  assign q_est   = PW'(prod[32:RCP_SH]);
  assign rem     = 16'(pg) - 16'(q) * 16'(WORD_BITS);
  assign q_fix   = (rem >= 16'(WORD_BITS)) ? q + PW'(1) : q;
  assign rem_fix = (rem >= 16'(WORD_BITS)) ? rem - 16'(WORD_BITS) : rem;

  // Lowest set bit in two steps: nonzero byte first, then bit within it
  assign word_pad = 64'(rd_data);

  always_comb begin
    grp_c = 3'd0;
    for (int g = 7; g >= 0; g--) begin
      if (word_pad[g*8 +: 8] != 8'd0) begin
        grp_c = 3'(g);
      end
    end
  end

  always_comb begin
    bit_c = 3'd0;
    for (int b = 7; b >= 0; b--) begin
      if (grp_byte[b]) begin
        bit_c = 3'(b);
      end
    end
  end

  assign new_hint_bit = HB_W'({grp, bit_c});
  assign hint_mask    = WORD_BITS'(1) << hint_bit;
  assign page_mask    = WORD_BITS'(1) << fb;

  // Flags for the sequencer
  always_comb begin
    flags.clr_more   = (scan_w != LAST_W);
    flags.in_fire    = in_fire;
    flags.is_free    = (op_reg == bpfa_pkg::OP_FREE);
    flags.count_zero = (free_count == '0);
    flags.count_one  = (free_count == CNT_W'(1));
    flags.scan_more  = word_zero && (scan_w != LAST_W);
    flags.word_zero  = word_zero;
    flags.out_range  = (32'(pg) >= TOTAL);
    flags.bit_set    = rd_data[fb];
    flags.out_free   = out_free;
  end

  // Memory port control
  always_comb begin
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_addr = scan_w;
    mem_wd   = '0;
    case (uw.act)
      bpfa_pkg::ACT_CLEAR: begin
        mem_we = 1'b1;
      end
      bpfa_pkg::ACT_READ_HINT: begin
        mem_re   = 1'b1;
        mem_addr = hint_word;
      end
      bpfa_pkg::ACT_CLEAR_HINT: begin
        mem_we   = 1'b1;
        mem_addr = hint_word;
        mem_wd   = rd_data & ~hint_mask;
      end
      bpfa_pkg::ACT_READ_SCAN: begin
        mem_re = 1'b1;
      end
      bpfa_pkg::ACT_READ_PAGE: begin
        mem_re   = 1'b1;
        mem_addr = fw;
      end
      bpfa_pkg::ACT_FREE_COMMIT: begin
        mem_we   = 1'b1;
        mem_addr = fw;
        mem_wd   = rd_data | page_mask;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wd;
    end
    if (mem_re) begin
      rd_data <= mem[mem_addr];
    end
  end

  // Control state: scan pointer, hint, free count, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_w     <= '0;
      hint_word  <= '0;
      hint_bit   <= '0;
      free_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      case (uw.act)
        bpfa_pkg::ACT_CLEAR: begin
          scan_w <= scan_w + WA_W'(1);
        end
        bpfa_pkg::ACT_READ_HINT: begin
          scan_w <= hint_word;
        end
        bpfa_pkg::ACT_CLEAR_HINT: begin
          free_count <= free_count - CNT_W'(1);
        end
        bpfa_pkg::ACT_SCAN_STEP: begin
          if (flags.scan_more) begin
            scan_w <= scan_w + WA_W'(1);
          end
        end
        bpfa_pkg::ACT_SET_HINT: begin
          hint_word <= scan_w;
          hint_bit  <= new_hint_bit;
        end
        bpfa_pkg::ACT_FREE_COMMIT: begin
          free_count <= free_count + CNT_W'(1);
          if (flags.count_zero || pg_lt_hint) begin
            hint_word <= fw;
            hint_bit  <= fb;
          end
        end
        default: begin
          scan_w <= scan_w;
        end
      endcase
      // load a new result or drop the one taken
      if (uw.act == bpfa_pkg::ACT_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    case (uw.act)
      bpfa_pkg::ACT_ACCEPT: begin
        if (in_fire) begin
          op_reg <= opcode;
          pg     <= page_number;
        end
      end
      bpfa_pkg::ACT_READ_HINT: begin
        res_page   <= PW'(hint_page);
        res_status <= bpfa_pkg::ST_OK;
      end
      bpfa_pkg::ACT_FIND_GROUP: begin
        grp      <= grp_c;
        grp_byte <= word_pad[grp_c*8 +: 8];
      end
      bpfa_pkg::ACT_RES_EMPTY: begin
        res_page   <= '0;
        res_status <= bpfa_pkg::ST_NO_FREE;
      end
      bpfa_pkg::ACT_DIV_EST: begin
        q        <= q_est;
        res_page <= '0;
      end
      bpfa_pkg::ACT_DIV_FIX: begin
        fw <= WA_W'(q_fix);
        fb <= HB_W'(rem_fix);
      end
      bpfa_pkg::ACT_FREE_COMMIT: begin
        res_status <= bpfa_pkg::ST_OK;
      end
      bpfa_pkg::ACT_RES_RANGE: begin
        res_status <= bpfa_pkg::ST_RANGE;
      end
      bpfa_pkg::ACT_RES_DUP: begin
        res_status <= bpfa_pkg::ST_DUP;
      end
      bpfa_pkg::ACT_EMIT: begin
        if (out_free) begin
          alloc_page <= res_page;
          status     <= res_status;
        end
      end
      default: begin
        q <= q;
      end
    endcase
  end

  // An empty report only when no page is counted free
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    (uw.act == bpfa_pkg::ACT_RES_EMPTY) |-> (free_count == '0))
    else $error("empty reported with pages counted free");

  // Allocation takes exactly one page from the count
  a_alloc_count: assert property (@(posedge clk) disable iff (rst)
    (uw.act == bpfa_pkg::ACT_CLEAR_HINT) |=>
      (free_count == CNT_W'($past(free_count) - CNT_W'(1))))
    else $error("free count not lowered by one on allocate");

  // A committed free adds exactly one page to the count
  a_free_count: assert property (@(posedge clk) disable iff (rst)
    (uw.act == bpfa_pkg::ACT_FREE_COMMIT) |=>
      (free_count == CNT_W'($past(free_count) + CNT_W'(1))))
    else $error("free count not raised by one on free");

  // The hint names a page inside the bitmap whenever a page is counted free
  a_hint_range: assert property (@(posedge clk) disable iff (rst)
    !flags.count_zero |-> (32'(hint_page) < TOTAL))
    else $error("hint points beyond the bitmap");

endmodule

// File: rtl/bitmap_page_frame_allocator.sv
// Page frame allocator over a free-page bitmap (set bit = free page), with a hint that
// always names the lowest free page. After reset the bitmap is cleared one word per
// cycle, during which no item is taken; software then frees pages to populate it. A free
// item splits the page number into word and bit, reads the word, checks for a duplicate
// and writes it back; a page beyond the bitmap is rejected without a memory access. An
// allocate item reads the hint word, clears the hint bit and scans forward for the next
// hint, which it skips when it takes the last free page; it reports empty without a
// memory access when no page is free. The single bitmap memory port is driven one read
// or write per step by a microcoded sequencer. Results sit in an output register, so the
// next item is taken while a result still waits to be collected.
module bitmap_page_frame_allocator #(
  parameter int unsigned NUM_WORDS = bpfa_pkg::NUM_WORDS_DEF,
  parameter int unsigned WORD_BITS = bpfa_pkg::WORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          opcode,
  input  logic [bpfa_pkg::PAGE_W-1:0]   page_number,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bpfa_pkg::PAGE_W-1:0]   alloc_page,
  output logic [1:0]                    status
);

  bpfa_pkg::uword_t uw;
  bpfa_pkg::flags_t flags;

  // Control store and step counter
  bpfa_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .uw    (uw)
  );

  // Bitmap memory, hint, count and result register
  bpfa_dp #(
    .NUM_WORDS (NUM_WORDS),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .uw          (uw),
    .flags       (flags),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .page_number (page_number),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .alloc_page  (alloc_page),
    .status      (status)
  );

endmodule
